// ===== hdl/tqws_pkg.sv =====
// tqws_pkg: types, event codes and steal preference table for the
// three-queue work-stealing scheduler. no dependencies.
package tqws_pkg;

  localparam int NUM_WORKERS     = 3;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int CNT_OUT_W       = 6;
  localparam int LABEL_W         = 16;
  localparam int DUR_W           = 4;
  localparam int JOB_W           = LABEL_W + DUR_W;

  // event codes
  localparam logic [1:0] EV_FINISHED = 2'd0;
  localparam logic [1:0] EV_STOLEN   = 2'd1;
  localparam logic [1:0] EV_STARTED  = 2'd2;
  localparam logic [1:0] EV_NOTHING  = 2'd3;

  // worker code that drops the offered job
  localparam logic [1:0] WORKER_DROP = 2'd3;

  typedef struct packed {
    logic               job_offered;
    logic [LABEL_W-1:0] job_label;
    logic [DUR_W-1:0]   job_duration;
    logic [1:0]         target_worker;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           event_kind;
    logic [1:0]           worker;
    logic [1:0]           victim_worker;
    logic [LABEL_W-1:0]   event_job;
    logic [CNT_OUT_W-1:0] count_w0;
    logic [CNT_OUT_W-1:0] count_w1;
    logic [CNT_OUT_W-1:0] count_w2;
    logic                 last;
  } out_item_t;

  // victim preference: thief 0 -> 2,1; thief 1 -> 0,2; thief 2 -> 1,0
  function automatic logic [1:0] steal_pref(input logic [1:0] thief, input logic pick);
    logic [1:0] v;
    v = 2'd0;
    case (thief)
      2'd0:    v = pick ? 2'd1 : 2'd2;
      2'd1:    v = pick ? 2'd2 : 2'd0;
      2'd2:    v = pick ? 2'd0 : 2'd1;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/three_queue_work_stealing_scheduler_core.sv =====
// three_queue_work_stealing_scheduler_core: top level of the job scheduler.
// depends on tqws_pkg and tqws_ram.
//
// Each input transfer is one scheduler tick over three worker ring queues held in
// one shared job memory: finish (count down or retire each head job), steal (an
// empty worker takes the tail job of a busier one, skipped while any queue is
// full), then insert of the offered job. A tick yields one to six result
// transfers, the last one flagged by last; a tick with no event yields one
// "nothing" item. The block takes no new item until the tick's last result sits
// in the output register. All memory traffic goes through the one read and one
// write port of the job memory; at most two steals happen in one tick, and a
// stalled output side lengthens the tick. Queue memory powers up undefined and
// needs no clearing; head and tail pointers reset to zero.
module three_queue_work_stealing_scheduler_core #(
  parameter int QUEUE_DEPTH = tqws_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tqws_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tqws_pkg::out_item_t out_data
);

  import tqws_pkg::*;

  localparam int SW       = $clog2(QUEUE_DEPTH);
  localparam int MEM_D    = NUM_WORKERS * QUEUE_DEPTH;
  localparam int AW       = $clog2(MEM_D);
  localparam logic [SW-1:0] SLOT_MAX = SW'(QUEUE_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FIN_CHK, S_FIN_ACT, S_STL_CHK, S_STL_ACT, S_INS, S_DONE
  } state_t;

  state_t          st_r, st_nxt;
  logic [1:0]      w_r, w_nxt;
  logic [1:0]      vic_r, vic_nxt;
  in_item_t        in_r;
  logic [SW-1:0]   head_r [NUM_WORKERS];
  logic [SW-1:0]   head_nxt [NUM_WORKERS];
  logic [SW-1:0]   tail_r [NUM_WORKERS];
  logic [SW-1:0]   tail_nxt [NUM_WORKERS];
  logic [SW-1:0]   cnt_r [NUM_WORKERS];
  logic [SW-1:0]   cnt_nxt [NUM_WORKERS];
  out_item_t       pend_r, pend_nxt;
  logic            pend_vld_r, pend_vld_nxt;
  out_item_t       out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [JOB_W-1:0] mem_wdata, mem_rdata;

  logic            out_free, can_post, any_full, post;
  logic [1:0]      ev_kind, ev_worker, ev_victim;
  logic [LABEL_W-1:0] ev_job;
  logic [1:0]      pref0, pref1;

  // slot step with wrap
  function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
    return (s == SLOT_MAX) ? '0 : s + SW'(1);
  endfunction

  function automatic logic [SW-1:0] slot_prev(input logic [SW-1:0] s);
    return (s == '0) ? SLOT_MAX : s - SW'(1);
  endfunction

  // worker base plus slot
  function automatic logic [AW-1:0] mem_addr(input logic [1:0] w, input logic [SW-1:0] s);
    logic [AW-1:0] base;
    base = '0;
    if (w == 2'd1) base = AW'(QUEUE_DEPTH);
    if (w == 2'd2) base = AW'(2 * QUEUE_DEPTH);
    return base + AW'(s);
  endfunction

  tqws_ram #(
    .DEPTH (MEM_D),
    .WIDTH (JOB_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign can_post = !pend_vld_r || out_free;
  assign any_full = (cnt_r[0] == SLOT_MAX) || (cnt_r[1] == SLOT_MAX) ||
                    (cnt_r[2] == SLOT_MAX);
  assign pref0    = steal_pref(w_r, 1'b0);
  assign pref1    = steal_pref(w_r, 1'b1);

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer
  always_comb begin
    st_nxt        = st_r;
    w_nxt         = w_r;
    vic_nxt       = vic_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    post          = 1'b0;
    ev_kind       = EV_NOTHING;
    ev_worker     = '0;
    ev_victim     = '0;
    ev_job        = '0;

    // output register drains on transfer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          w_nxt  = '0;
          st_nxt = S_FIN_CHK;
        end
      end

      S_FIN_CHK: begin
        if (cnt_r[w_r] != '0) begin
          mem_re    = 1'b1;
          mem_raddr = mem_addr(w_r, slot_next(head_r[w_r]));
          st_nxt    = S_FIN_ACT;
        end else if (w_r == 2'd2) begin
          w_nxt  = '0;
          st_nxt = S_STL_CHK;
        end else begin
          w_nxt = w_r + 2'd1;
        end
      end

      S_FIN_ACT: begin
        if (mem_rdata[DUR_W-1:0] != '0) begin
          // count down the head job in place
          mem_we    = 1'b1;
          mem_waddr = mem_addr(w_r, slot_next(head_r[w_r]));
          mem_wdata = mem_rdata - JOB_W'(1);
          w_nxt     = (w_r == 2'd2) ? 2'd0 : w_r + 2'd1;
          st_nxt    = (w_r == 2'd2) ? S_STL_CHK : S_FIN_CHK;
        end else if (can_post) begin
          // retire the head job
          head_nxt[w_r] = slot_next(head_r[w_r]);
          cnt_nxt[w_r]  = cnt_r[w_r] - SW'(1);
          post          = 1'b1;
          ev_kind       = EV_FINISHED;
          ev_worker     = w_r;
          ev_job        = mem_rdata[JOB_W-1:DUR_W];
          w_nxt         = (w_r == 2'd2) ? 2'd0 : w_r + 2'd1;
          st_nxt        = (w_r == 2'd2) ? S_STL_CHK : S_FIN_CHK;
        end
      end

      S_STL_CHK: begin
        if (!any_full && cnt_r[w_r] == '0 && cnt_r[pref0] > SW'(1)) begin
          vic_nxt   = pref0;
          mem_re    = 1'b1;
          mem_raddr = mem_addr(pref0, tail_r[pref0]);
          st_nxt    = S_STL_ACT;
        end else if (!any_full && cnt_r[w_r] == '0 && cnt_r[pref1] > SW'(1)) begin
          vic_nxt   = pref1;
          mem_re    = 1'b1;
          mem_raddr = mem_addr(pref1, tail_r[pref1]);
          st_nxt    = S_STL_ACT;
        end else if (w_r == 2'd2) begin
          st_nxt = S_INS;
        end else begin
          w_nxt = w_r + 2'd1;
        end
      end

      S_STL_ACT: begin
        if (can_post) begin
          // move victim tail job to thief tail
          mem_we          = 1'b1;
          mem_waddr       = mem_addr(w_r, slot_next(tail_r[w_r]));
          mem_wdata       = mem_rdata;
          tail_nxt[vic_r] = slot_prev(tail_r[vic_r]);
          cnt_nxt[vic_r]  = cnt_r[vic_r] - SW'(1);
          tail_nxt[w_r]   = slot_next(tail_r[w_r]);
          cnt_nxt[w_r]    = cnt_r[w_r] + SW'(1);
          post            = 1'b1;
          ev_kind         = EV_STOLEN;
          ev_worker       = w_r;
          ev_victim       = vic_r;
          ev_job          = mem_rdata[JOB_W-1:DUR_W];
          st_nxt          = (w_r == 2'd2) ? S_INS : S_STL_CHK;
          w_nxt           = (w_r == 2'd2) ? w_r : w_r + 2'd1;
        end
      end

      S_INS: begin
        if (!in_r.job_offered || in_r.target_worker == WORKER_DROP || any_full) begin
          st_nxt = S_DONE;
        end else if (can_post) begin
          mem_we    = 1'b1;
          mem_waddr = mem_addr(in_r.target_worker, slot_next(tail_r[in_r.target_worker]));
          mem_wdata = {in_r.job_label, in_r.job_duration};
          tail_nxt[in_r.target_worker] = slot_next(tail_r[in_r.target_worker]);
          cnt_nxt[in_r.target_worker]  = cnt_r[in_r.target_worker] + SW'(1);
          post      = 1'b1;
          ev_kind   = EV_STARTED;
          ev_worker = in_r.target_worker;
          ev_job    = in_r.job_label;
          st_nxt    = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          // final transfer of the tick
          out_valid_nxt = 1'b1;
          if (pend_vld_r) begin
            out_nxt = pend_r;
          end else begin
            out_nxt = '{event_kind: EV_NOTHING, worker: '0, victim_worker: '0,
                        event_job: '0, count_w0: CNT_OUT_W'(cnt_r[0]),
                        count_w1: CNT_OUT_W'(cnt_r[1]),
                        count_w2: CNT_OUT_W'(cnt_r[2]), last: 1'b0};
          end
          out_nxt.last = 1'b1;
          pend_vld_nxt = 1'b0;
          st_nxt       = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase

    // new event: earlier pending one goes out, new one is held
    if (post) begin
      if (pend_vld_r) begin
        out_nxt       = pend_r;
        out_valid_nxt = 1'b1;
      end
      pend_vld_nxt = 1'b1;
      pend_nxt     = '{event_kind: ev_kind, worker: ev_worker, victim_worker: ev_victim,
                       event_job: ev_job, count_w0: CNT_OUT_W'(cnt_nxt[0]),
                       count_w1: CNT_OUT_W'(cnt_nxt[1]),
                       count_w2: CNT_OUT_W'(cnt_nxt[2]), last: 1'b0};
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      w_r         <= '0;
      vic_r       <= '0;
      head_r      <= '{default: '0};
      tail_r      <= '{default: '0};
      cnt_r       <= '{default: '0};
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      w_r         <= w_nxt;
      vic_r       <= vic_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    if (st_r == S_IDLE && in_valid) begin
      in_r <= in_data;
    end
  end

endmodule

// ===== hdl/tqws_ram.sv =====
// tqws_ram: single-port-write, single-port-read job memory with registered read.
// no dependencies.
module tqws_ram #(
  parameter int DEPTH = 192,
  parameter int WIDTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
